FILE: hdl/tbpf_pkg.sv
package tbpf_pkg;

  localparam int VRAM_DEPTH = 8192;
  localparam int VRAM_AW    = 13;
  localparam int BYTE_W     = 8;

  // Two-entry queues between the front, the back and the result port.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [QCNT_W-1:0] QFULL_CNT = QCNT_W'(QDEPTH);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic [2:0] REG_SCROLL_X = 3'd0;
  localparam logic [2:0] REG_SCROLL_Y = 3'd1;
  localparam logic [2:0] REG_MAP_SEL  = 3'd2;
  localparam logic [2:0] REG_TILE_MODE = 3'd3;
  localparam logic [2:0] REG_PALETTE  = 3'd4;

  localparam logic [7:0] PALETTE_RESET = 8'd252;

  // Both tile maps sit in the top quarter of video memory (0x1800, 0x1C00).
  localparam logic [1:0] MAP_REGION = 2'b11;

  typedef struct packed {
    logic        kind;
    logic [12:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0] shade;
    logic [1:0] color_index;
  } out_word_t;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       bg_map_select;
    logic       tile_data_mode;
    logic [7:0] bg_palette;
  } cfg_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic               is_fetch;
    logic [VRAM_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
    logic [2:0]         row;
    logic [2:0]         col;
  } cmd_t;

  // Address of the low plane byte of one tile row. In signed mode indices
  // below 128 live in the upper 4 KiB block; the OR stands in for the add
  // because index*16 + row*2 never reaches bit 12.
  function automatic logic [VRAM_AW-1:0] tile_row_addr(
    input logic [7:0] idx,
    input logic       signed_mode,
    input logic [2:0] row
  );
    logic upper;
    upper = signed_mode & ~idx[7];
    return {upper, idx, row, 1'b0};
  endfunction

endpackage

FILE: hdl/tile_background_pixel_fetch_core.sv
// Background pixel fetch over an 8 KiB video memory. A write word stores one
// byte through the back end and gives no result; a pixel word gives one
// result after three dependent reads of the single memory read port (map
// entry, low plane byte, high plane byte). A new word is taken only once the
// previous pixel word is at its high plane byte, and a pixel word only if its
// result will find a free slot in the result queue. Words are served strictly
// in order. Memory has no reset; reading a byte that was never written
// returns garbage. Registers (scroll_x, scroll_y, bg_map_select,
// tile_data_mode, bg_palette at byte addresses 0,4,8,12,16) may only be
// changed while the block holds no word.
module tile_background_pixel_fetch_core import tbpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word,
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [2:0] reg_idx;
  logic       cmd_valid;
  logic       cmd_pop;
  cmd_t       cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_SCROLL_X:  cfg_nxt.scroll_x       = pwdata[7:0];
        REG_SCROLL_Y:  cfg_nxt.scroll_y       = pwdata[7:0];
        REG_MAP_SEL:   cfg_nxt.bg_map_select  = pwdata[0];
        REG_TILE_MODE: cfg_nxt.tile_data_mode = pwdata[0];
        REG_PALETTE:   cfg_nxt.bg_palette     = pwdata[7:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCROLL_X:  prdata = {24'd0, cfg_r.scroll_x};
      REG_SCROLL_Y:  prdata = {24'd0, cfg_r.scroll_y};
      REG_MAP_SEL:   prdata = {31'd0, cfg_r.bg_map_select};
      REG_TILE_MODE: prdata = {31'd0, cfg_r.tile_data_mode};
      REG_PALETTE:   prdata = {24'd0, cfg_r.bg_palette};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{scroll_x: 8'd0, scroll_y: 8'd0, bg_map_select: 1'b0,
                 tile_data_mode: 1'b0, bg_palette: PALETTE_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tbpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tbpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

FILE: hdl/tbpf_ram.sv
module tbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/tbpf_front.sv
module tbpf_front import tbpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     push,
  output logic     full,
  input  in_word_t in_word,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);

  cmd_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;
  logic [7:0]        bx, by;
  cmd_t              new_cmd;

  assign full      = (cnt_r == QFULL_CNT);
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Scroll is applied here; the user keeps configuration steady while any word is inside (not enforced).
  assign bx = in_word.pixel_x + cfg.scroll_x;
  assign by = in_word.pixel_y + cfg.scroll_y;

  always_comb begin
    new_cmd          = '0;
    new_cmd.is_fetch = (in_word.kind == KIND_FETCH);
    if (in_word.kind == KIND_FETCH) begin
      new_cmd.addr = {MAP_REGION, cfg.bg_map_select, by[7:3], bx[7:3]};
      new_cmd.row  = by[2:0];
      new_cmd.col  = bx[2:0];
    end else begin
      new_cmd.addr = in_word.mem_address;
      new_cmd.data = in_word.mem_data;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(do_push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(do_pop);
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

FILE: hdl/tbpf_back.sv
module tbpf_back import tbpf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAP  = 2'd1;
  localparam logic [1:0] ST_LO   = 2'd2;
  localparam logic [1:0] ST_HI   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [2:0]         row_r, row_nxt;
  logic [2:0]         col_r, col_nxt;
  logic [VRAM_AW-1:0] lo_addr_r, lo_addr_nxt;
  logic [BYTE_W-1:0]  lo_byte_r, lo_byte_nxt;

  logic               ram_we;
  logic [VRAM_AW-1:0] ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  out_word_t          oq_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  oq_wr_r, oq_rd_r;
  logic [QCNT_W-1:0]  oq_cnt_r, oq_cnt_nxt;
  logic               oq_push, oq_pop;
  out_word_t          result;

  logic               slot_free;
  logic               launch;
  logic [2:0]         bit_sel;
  logic [1:0]         color;

  tbpf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.addr),
    .wdata (cmd.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign oq_push    = (state_r == ST_HI);
  assign oq_pop     = pop && !empty;
  assign oq_cnt_nxt = oq_cnt_r + QCNT_W'(oq_push) - QCNT_W'(oq_pop);

  // A fetch may start only if its result will find a free slot; the
  // count can only fall while the fetch is in flight.
  assign slot_free = (state_r == ST_IDLE) || (state_r == ST_HI);
  assign launch    = slot_free && cmd_valid && (!cmd.is_fetch || (oq_cnt_nxt != QFULL_CNT));
  assign cmd_pop   = launch;
  assign ram_we    = launch && !cmd.is_fetch;

  assign bit_sel = ~col_r;
  assign color   = {ram_rdata[bit_sel], lo_byte_r[bit_sel]};
  always_comb begin
    result             = '0;
    result.color_index = color;
    result.shade       = cfg.bg_palette[{color, 1'b0} +: 2];
  end

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    lo_addr_nxt = lo_addr_r;
    lo_byte_nxt = lo_byte_r;
    ram_raddr   = cmd.addr;
    unique case (state_r)
      ST_MAP: begin
        lo_addr_nxt = tile_row_addr(ram_rdata, cfg.tile_data_mode, row_r);
        ram_raddr   = lo_addr_nxt;
        state_nxt   = ST_LO;
      end
      ST_LO: begin
        lo_byte_nxt = ram_rdata;
        ram_raddr   = {lo_addr_r[VRAM_AW-1:1], 1'b1};
        state_nxt   = ST_HI;
      end
      ST_IDLE, ST_HI: begin
        state_nxt = ST_IDLE;
        if (launch && cmd.is_fetch) begin
          state_nxt = ST_MAP;
          row_nxt   = cmd.row;
          col_nxt   = cmd.col;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      oq_wr_r  <= oq_wr_r + QPTR_W'(oq_push);
      oq_rd_r  <= oq_rd_r + QPTR_W'(oq_pop);
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    lo_addr_r <= lo_addr_nxt;
    lo_byte_r <= lo_byte_nxt;
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= result;
    end
  end

  assign empty    = (oq_cnt_r == '0);
  assign out_word = oq_mem_r[oq_rd_r];

  a_map_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAP |=> state_r == ST_LO)
    else $error("map read not followed by low plane read");

  a_lo_then_hi: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LO |=> state_r == ST_HI)
    else $error("low plane read not followed by high plane read");

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_cnt_r != QFULL_CNT) || oq_pop)
    else $error("result queue overflow");

  a_write_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE) || (state_r == ST_HI))
    else $error("memory write during a fetch read");

endmodule
